### rtl/core/itaf_pkg.sv
package itaf_pkg;

	// width of the number to convert
	localparam int VALUE_BITS = 32;

	// decimal digits of the largest magnitude, hex digits of the widest value
	localparam int DEC_DIGITS = (VALUE_BITS * 3) / 10 + 1;
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int DIG_W      = NUM_DIGITS * 4;
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	// conversion modes
	typedef enum logic [1:0] {
		CMD_SIGNED   = 2'd0,
		CMD_UNSIGNED = 2'd1,
		CMD_HEX      = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;

	// glyph of one digit, 0-9 then a-f
	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) begin
			g = CHAR_ZERO + {4'd0, d};
		end else begin
			g = CHAR_LOW_A + {4'd0, d - 4'd10};
		end
		return g;
	endfunction

endpackage

### rtl/core/itaf_dabble_step.sv
module itaf_dabble_step (
	input  logic [itaf_pkg::DIG_W-1:0] dig,
	input  logic                       bit_in,
	output logic [itaf_pkg::DIG_W-1:0] dig_next
);
	import itaf_pkg::*;

	logic [DIG_W-1:0] adj;

	// add three to every digit of five or more, digits are independent
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (dig[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = dig[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = dig[i*4 +: 4];
			end
		end
	end

	// shift the next magnitude bit in
	assign dig_next = {adj[DIG_W-2:0], bit_in};

endmodule

### rtl/core/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// Input channel (in_valid, in_stall, cmd, value): one number and a mode,
// signed decimal, unsigned decimal or lowercase hex. Mode 3 is dropped.
// Output channel (out_valid, out_stall, char_out, last): one ASCII
// character per item, most significant first, last set on the final one.
// A leading '-' comes first for a negative value in signed mode.
// Decimal: after the item is loaded, one shift-and-adjust step per cycle
// through a single BCD adjust unit, one step for each of the VALUE_BITS.
// Hex skips that unit. Leading zero digits are then dropped one per cycle,
// keeping at least one digit, then one character leaves per cycle while
// out_stall does not hold the output register.
// in_stall stays high from the accepted item until its last character is
// in the output register. The output register holds a character while
// out_stall is high and the sequencer waits on it.
// Reset (arst_n low) clears the sequencer and the output valid at once.
module integer_to_ascii_formatter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic [itaf_pkg::VALUE_BITS-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      char_out,
	output logic                            last
);
	import itaf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [DIG_W-1:0]      dig_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_CNT_W-1:0]  dig_cnt_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [DIG_W-1:0]      dig_step;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  neg_in;
	logic [3:0]            top_dig;
	logic                  slot_free;
	logic                  emit_fire;

	// shared bcd adjust unit
	itaf_dabble_step u_step (
		.dig      (dig_q),
		.bit_in   (mag_q[VALUE_BITS-1]),
		.dig_next (dig_step)
	);

	// sign and magnitude of the incoming number
	assign neg_in    = (cmd_t'(cmd) == CMD_SIGNED) && value[VALUE_BITS-1];
	assign mag_in    = neg_in ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
	assign top_dig   = dig_q[DIG_W-1 -: 4];
	assign slot_free = !out_valid_q || !out_stall;
	assign emit_fire = (state_q == ST_EMIT) && slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q     <= neg_in;
						mag_q     <= mag_in;
						dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
						bit_cnt_q <= BIT_CNT_W'(VALUE_BITS);
						unique case (cmd_t'(cmd))
							CMD_SIGNED, CMD_UNSIGNED: begin
								dig_q   <= '0;
								state_q <= ST_CONV;
							end
							CMD_HEX: begin
								dig_q   <= DIG_W'(value);
								state_q <= ST_SKIP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CONV: begin
					dig_q     <= dig_step;
					mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keep at least one digit
					if (top_dig == 4'd0 && dig_cnt_q > DIG_CNT_W'(1)) begin
						dig_q     <= {dig_q[DIG_W-5:0], 4'd0};
						dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (neg_q) begin
							char_q <= CHAR_MINUS;
							last_q <= 1'b0;
							neg_q  <= 1'b0;
						end else begin
							char_q    <= digit_glyph(top_dig);
							last_q    <= (dig_cnt_q == DIG_CNT_W'(1));
							dig_q     <= {dig_q[DIG_W-5:0], 4'd0};
							dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
							if (dig_cnt_q == DIG_CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
